// ===== sv/dpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared types and constants for the double-ended priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned ValueWidth      = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_GET_MIN = 2'd1,
    OP_GET_MAX = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command that every cell of a chain carries out
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SHIFT  = 2'd2
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e                    cmd;
    logic signed [ValueWidth-1:0] key;
  } chain_ctrl_t;

endpackage

// ===== sv/dpq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_in_if / dpq_out_if
// Valid/ready channels carrying commands into and results out of the queue.
// ----------------------------------------------------------------------------
interface dpq_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface dpq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic        [1:0]  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== sv/dpq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_cell
// One slot of a sorted chain: holds a value, opens a gap on insert, or takes
// its right neighbor's value on a shift toward the head.
// ----------------------------------------------------------------------------
module dpq_cell #(
  parameter bit Descend = 1'b0
) (
  input  logic                                   clk_i,
  input  dpq_pkg::chain_ctrl_t                   ctrl_i,
  input  logic                                   occ_i,
  input  logic signed [dpq_pkg::ValueWidth-1:0]  prev_value_i,
  input  logic                                   prev_beats_i,
  input  logic signed [dpq_pkg::ValueWidth-1:0]  next_value_i,
  output logic signed [dpq_pkg::ValueWidth-1:0]  value_o,
  output logic                                   beats_o
);
  import dpq_pkg::*;

  logic signed [ValueWidth-1:0] value_q, value_d;
  logic                         after_key;

  // true when the held value belongs after the key in chain order
  assign after_key = Descend ? (value_q < ctrl_i.key) : (value_q > ctrl_i.key);
  assign beats_o   = occ_i & after_key;
  assign value_o   = value_q;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (prev_beats_i) begin
          value_d = prev_value_i;
        end else if (!occ_i || after_key) begin
          value_d = ctrl_i.key;
        end
      end
      CMD_SHIFT: value_d = next_value_i;
      default:   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== sv/dpq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_chain
// Row of cells kept sorted, ascending or descending; the head is cell 0.
// ----------------------------------------------------------------------------
module dpq_chain #(
  parameter int unsigned Depth   = dpq_pkg::DefaultCapacity,
  parameter bit          Descend = 1'b0
) (
  input  logic                                   clk_i,
  input  dpq_pkg::chain_ctrl_t                   ctrl_i,
  input  logic [Depth-1:0]                       occ_i,
  output logic signed [dpq_pkg::ValueWidth-1:0]  head_o
);
  import dpq_pkg::*;

  logic signed [ValueWidth-1:0] value [Depth];
  logic                         beats [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [ValueWidth-1:0] prev_value;
    logic                         prev_beats;
    logic signed [ValueWidth-1:0] next_value;

    if (i == 0) begin : g_head
      assign prev_value = ctrl_i.key;
      assign prev_beats = 1'b0;
    end else begin : g_body
      assign prev_value = value[i-1];
      assign prev_beats = beats[i-1];
    end

    // tail cell has nothing to pull in; its content is unoccupied afterwards
    if (i == Depth - 1) begin : g_tail
      assign next_value = value[i];
    end else begin : g_inner
      assign next_value = value[i+1];
    end

    dpq_cell #(
      .Descend (Descend)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .occ_i        (occ_i[i]),
      .prev_value_i (prev_value),
      .prev_beats_i (prev_beats),
      .next_value_i (next_value),
      .value_o      (value[i]),
      .beats_o      (beats[i])
    );
  end

  assign head_o = value[0];

endmodule

// ===== sv/double_ended_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Double-ended priority queue of signed 32-bit values built from two sorted
// cell chains.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command per transaction: insert value, remove minimum
//   or remove maximum. out_o returns exactly one result per command: the
//   removed value (zero for inserts and errors) and a status of ok, empty
//   or full. An unused opcode returns zero with status ok.
//   Every command completes in the cycle it is accepted; its result is
//   registered and appears on out_o in the next cycle. One command per cycle
//   is sustained while out_o is drained, as every cell of both chains
//   updates at once (each cell compares its value to the broadcast key).
//   The queue is held twice, ascending and descending, so both the minimum
//   and the maximum sit at a chain head; removing from one chain just drops
//   the tail of the other through the occupancy count.
//   Reset empties the queue (occupancy to zero) and clears the output valid.
//   When out_o stalls, one result waits in the output register and in_i
//   deasserts ready until it is taken.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
  parameter int unsigned Capacity = dpq_pkg::DefaultCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpq_in_if.sink    in_i,
  dpq_out_if.source out_o
);
  import dpq_pkg::*;

  localparam int unsigned CountWidth = $clog2(Capacity + 1);

  logic [CountWidth-1:0]        count_q, count_d;
  logic                         out_valid_q;
  logic signed [ValueWidth-1:0] result_q, result_d;
  status_e                      status_q, status_d;
  logic                         accept;
  logic                         empty, full;
  chain_ctrl_t                  asc_ctrl, desc_ctrl;
  logic [Capacity-1:0]          occ;
  logic signed [ValueWidth-1:0] min_head, max_head;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CountWidth'(Capacity));

  for (genvar i = 0; i < Capacity; i++) begin : g_occ
    assign occ[i] = (count_q > CountWidth'(i));
  end

  always_comb begin
    asc_ctrl.cmd  = CMD_HOLD;
    asc_ctrl.key  = in_i.value;
    desc_ctrl.cmd = CMD_HOLD;
    desc_ctrl.key = in_i.value;
    count_d       = count_q;
    result_d      = '0;
    status_d      = ST_OK;
    if (accept) begin
      unique case (opcode_e'(in_i.opcode))
        OP_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            asc_ctrl.cmd  = CMD_INSERT;
            desc_ctrl.cmd = CMD_INSERT;
            count_d       = count_q + 1'b1;
          end
        end
        OP_GET_MIN: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            asc_ctrl.cmd = CMD_SHIFT;
            result_d     = min_head;
            count_d      = count_q - 1'b1;
          end
        end
        OP_GET_MAX: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            desc_ctrl.cmd = CMD_SHIFT;
            result_d      = max_head;
            count_d       = count_q - 1'b1;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  dpq_chain #(
    .Depth   (Capacity),
    .Descend (1'b0)
  ) u_asc_chain (
    .clk_i  (clk_i),
    .ctrl_i (asc_ctrl),
    .occ_i  (occ),
    .head_o (min_head)
  );

  dpq_chain #(
    .Depth   (Capacity),
    .Descend (1'b1)
  ) u_desc_chain (
    .clk_i  (clk_i),
    .ctrl_i (desc_ctrl),
    .occ_i  (occ),
    .head_o (max_head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = result_q;
  assign out_o.status       = status_q;

endmodule
